/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module of this project.
// Each macro expects a clock named clk; CHK_ASSERT also expects an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, disabled while reset is applied.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk that also holds during reset.
`define CHK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mcrx_pkg.sv */
// ----------------------------------------------------------------------------
// mcrx_pkg
// Constants and types shared by the receive demultiplexer queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrx_pkg;

  // Block configuration.
  localparam int NUM_CORES     = 4;
  localparam int QUEUE_DEPTH   = 256;
  localparam int PAYLOAD_BYTES = 4;

  // Derived widths.
  localparam int CORE_W  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int PHASE_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int MEM_DEPTH = NUM_CORES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);

  // Field widths of the stream beats.
  localparam int BYTE_W = 8;
  localparam int SEL_W  = 2;

  // Beat kinds carried on in_tuser.
  typedef enum logic {
    OP_RX_BYTE = 1'b0,
    OP_POP     = 1'b1
  } op_t;

  // Control from the queue controller to the store and the result stage.
  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              pop_hit;
    logic              hdr_err;
  } qctl_t;

endpackage

`default_nettype wire

/* rtl/core/mcrx_store.sv */
// ----------------------------------------------------------------------------
// mcrx_store
// Byte store holding the ring queues of all cores, one access per cycle,
// with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrx_store (
  input  wire                           clk,
  input  wire                           we,
  input  wire                           re,
  input  wire  [mcrx_pkg::ADDR_W-1:0]   addr,
  input  wire  [mcrx_pkg::BYTE_W-1:0]   wdata,
  output logic [mcrx_pkg::BYTE_W-1:0]   rdata_r
);
  import mcrx_pkg::*;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];

  // Single port: write or read at the one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mcrx_ctrl.sv */
// ----------------------------------------------------------------------------
// mcrx_ctrl
// Frame tracking and per-core ring pointers; issues at most one store access for
// each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrx_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          accept,
  input  wire                          op,
  input  wire  [mcrx_pkg::BYTE_W-1:0]  rx_byte,
  input  wire  [mcrx_pkg::SEL_W-1:0]   core_sel,
  output mcrx_pkg::qctl_t              ctl
);
  import mcrx_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CORE_W-1:0]  core_r, core_nxt;
  logic               drop_r, drop_nxt;
  logic [PTR_W-1:0]   head_r [NUM_CORES];
  logic [PTR_W-1:0]   head_nxt [NUM_CORES];
  logic [PTR_W-1:0]   tail_r [NUM_CORES];
  logic [PTR_W-1:0]   tail_nxt [NUM_CORES];

  logic               is_pop;
  logic               sel_ok;
  logic               hdr_bad;
  logic               do_push;
  logic               do_pop;
  logic [CORE_W-1:0]  idx;
  logic [PTR_W-1:0]   head_cur;
  logic [PTR_W-1:0]   tail_cur;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   tail_inc;
  logic [PTR_W-1:0]   ptr_sel;

  // Advance a ring pointer with wrap at the queue depth.
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Decode the beat and pick the one queue it touches.
  always_comb begin
    is_pop   = (op == OP_POP);
    sel_ok   = ({{(BYTE_W - SEL_W){1'b0}}, core_sel} < BYTE_W'(NUM_CORES));
    hdr_bad  = (rx_byte >= BYTE_W'(NUM_CORES));
    idx      = is_pop ? CORE_W'(core_sel) : core_r;
    head_cur = head_r[idx];
    tail_cur = tail_r[idx];
    head_inc = next_slot(head_cur);
    tail_inc = next_slot(tail_cur);
    do_push  = accept && !is_pop && (phase_r != '0) && !drop_r;
    do_pop   = accept && is_pop && sel_ok && (head_cur != tail_cur);
    ptr_sel  = is_pop ? head_cur : tail_cur;
  end

  // Framing state: header first, then the payload bytes of the frame.
  always_comb begin
    phase_nxt = phase_r;
    core_nxt  = core_r;
    drop_nxt  = drop_r;
    if (accept && !is_pop) begin
      if (phase_r == '0) begin
        drop_nxt  = hdr_bad;
        core_nxt  = hdr_bad ? '0 : CORE_W'(rx_byte);
        phase_nxt = PHASE_W'(1);
      end else if (phase_r >= PHASE_W'(PAYLOAD_BYTES)) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + PHASE_W'(1);
      end
    end
  end

  // Pointer updates; a push onto a full queue drops its oldest byte.
  always_comb begin
    for (int i = 0; i < NUM_CORES; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
    end
    if (do_push) begin
      tail_nxt[idx] = tail_inc;
      if (tail_inc == head_cur) begin
        head_nxt[idx] = head_inc;
      end
    end else if (do_pop) begin
      head_nxt[idx] = head_inc;
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      core_r  <= '0;
      drop_r  <= 1'b0;
      for (int i = 0; i < NUM_CORES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      core_r  <= core_nxt;
      drop_r  <= drop_nxt;
      for (int i = 0; i < NUM_CORES; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
      end
    end
  end

  // Store access and flags for the result stage.
  always_comb begin
    ctl.mem_we    = do_push;
    ctl.mem_re    = do_pop;
    ctl.mem_addr  = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_sel);
    ctl.mem_wdata = rx_byte;
    ctl.pop_hit   = do_pop;
    ctl.hdr_err   = accept && !is_pop && (phase_r == '0) && hdr_bad;
  end

endmodule

`default_nettype wire

/* rtl/core/multi_core_rx_demux_queues.sv */
// ----------------------------------------------------------------------------
// multi_core_rx_demux_queues
// Receive demultiplexer feeding one overwrite-oldest ring queue per core.
// ----------------------------------------------------------------------------
// Link bytes arrive as frames of one core-id header byte and four payload
// bytes; payload goes into the ring queue of the named core, and a full queue
// loses its oldest byte, so each queue holds at most 255 bytes. A pop beat
// names a core and returns its oldest byte. The block takes one beat per
// clock unless stalled and gives exactly one result beat for each, through
// its store stage and result register; the single-port byte store, one
// write or one read per cycle, sets the rate. Header ids of 4 or more raise
// header_error and that frame's payload is discarded. The store has no
// reset; only written entries are ever read, so no clearing pass is needed.
`default_nettype none

module multi_core_rx_demux_queues (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] rx_byte, [9:8] core_sel, [15:10] zero
  input  wire         in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] pop_byte
  output logic [1:0]  out_tuser   // [0] pop_valid, [1] header_error
);
  import mcrx_pkg::*;

  logic              accept;
  logic              s1_go;
  qctl_t             ctl;
  logic [BYTE_W-1:0] rd_data;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_hit_r;
  logic              s1_herr_r;
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_hit_r;
  logic              out_herr_r;

  // Handshake: the store stage moves on whenever the result register frees.
  assign s1_go     = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_go;
  assign accept    = in_tvalid && in_tready;

  mcrx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (in_tuser),
    .rx_byte  (in_tdata[BYTE_W-1:0]),
    .core_sel (in_tdata[BYTE_W+SEL_W-1:BYTE_W]),
    .ctl      (ctl)
  );

  mcrx_store u_store (
    .clk     (clk),
    .we      (ctl.mem_we),
    .re      (ctl.mem_re),
    .addr    (ctl.mem_addr),
    .wdata   (ctl.mem_wdata),
    .rdata_r (rd_data)
  );

  // Valid flags of the store stage and the result register.
  always_comb begin
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    out_v_nxt = s1_go ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Flags travel beside the store read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r  <= ctl.pop_hit;
      s1_herr_r <= ctl.hdr_err;
    end
  end

  // Result register; the byte reads as zero unless a pop found data.
  always_ff @(posedge clk) begin
    if (s1_go && s1_v_r) begin
      out_hit_r  <= s1_hit_r;
      out_herr_r <= s1_herr_r;
      out_byte_r <= s1_hit_r ? rd_data : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_herr_r, out_hit_r};

endmodule

`default_nettype wire

/* rtl/core/mcrx_checker.sv */
// ----------------------------------------------------------------------------
// mcrx_checker
// Port-level checks of the receive demultiplexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mcrx_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [15:0] in_tdata,
  input wire        in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [7:0]  out_tdata,
  input wire [1:0]  out_tuser
);

  // A result beat with no popped byte carries a zero byte.
  `CHK_ASSERT(a_byte_zero, out_tvalid && !out_tuser[0] |-> out_tdata == 8'd0, "byte not zero")

  // A result beat never flags both a popped byte and a header error.
  `CHK_ASSERT(a_excl, out_tvalid |-> !(out_tuser[0] && out_tuser[1]), "pop and header error")

  // A stalled result beat holds its contents.
  `CHK_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled beat changed")

  // No result beat appears in the cycle after reset.
  `CHK_ASSERT_RST(a_rst, !rst_n |=> !out_tvalid, "result after reset")

endmodule

bind multi_core_rx_demux_queues mcrx_checker u_mcrx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
